FILE: src/pcq_pkg.sv
// Shared constants for the pitch class quantizer.
// Border, register indexes and search mode codes; no dependencies.
package pcq_pkg;

    // Output window is +/- this many semitones
    localparam int BORDER_SEMIS = 120;

    localparam logic signed [8:0] BORDER_POS = 9'(BORDER_SEMIS);
    localparam logic signed [8:0] BORDER_NEG = -9'(BORDER_SEMIS);

    // Configuration register indexes
    localparam logic REG_ALLOWED_MASK = 1'b0;
    localparam logic REG_SEARCH_MODE  = 1'b1;

    // Search mode codes (code three behaves as nearest)
    localparam logic [1:0] MODE_NEAREST  = 2'd0;
    localparam logic [1:0] MODE_UP       = 2'd1;
    localparam logic [1:0] MODE_DOWN     = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    // Mod-12 helper: bias keeps the semitone positive, 171/2048 ~ 1/12
    localparam logic [8:0] PC_BIAS  = 9'd132;
    localparam logic [7:0] RECIP_12 = 8'd171;

    localparam logic [11:0] MASK_RESET = 12'hFFF;

endpackage

FILE: src/pitch_class_quantizer.sv
// Pitch class quantizer: four-stage pipeline from fixed-point pitch to an
// allowed semitone. Depends on pcq_pkg.
//
// Usage:
//   Input channel: pitch_in (semitones, 8 fraction bits) with in_valid and
//   in_ready. Output channel: quantized_semitone with out_valid/out_ready.
//   Config port: wr_en, wr_index, wr_data; index 0 is the 12-bit allowed
//   pitch class mask, index 1 the search mode (0 nearest, 1 up, 2 down).
//   Write config only while no item is in flight.
// Stages: round/clamp, mod 12, mask rotate and priority pick, border check
//   and select, one register each.
// Throughput: one item per cycle; each stage holds one item with its own
//   valid bit, so the block takes a new item every cycle the output drains.
// Stall: a low out_ready holds the output register; earlier stages keep
//   filling empty slots and stop only when the stage ahead is full.
// Reset: all valid bits clear, mask resets to all classes allowed, mode
//   to nearest.
module pitch_class_quantizer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic signed [15:0] pitch_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [7:0] quantized_semitone,
    input  logic              wr_en,
    input  logic              wr_index,
    input  logic [11:0]       wr_data
);

    // Configuration registers
    logic [11:0] allowed_mask_reg;
    logic [1:0]  search_mode_reg;

    // Stage valid bits and ready chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    // Stage payloads
    logic signed [7:0] s1_semi_reg, s1_semi_next;
    logic signed [7:0] s2_semi_reg;
    logic [3:0]        s2_pc_reg, s2_pc_next;
    logic signed [7:0] s3_semi_reg;
    logic              s3_hit_reg, s3_hit_next;
    logic [3:0]        s3_up_dist_reg, s3_up_dist_next;
    logic [3:0]        s3_dn_dist_reg, s3_dn_dist_next;
    logic [1:0]        s3_mode_reg;
    logic signed [7:0] s4_result_reg, s4_result_next;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allowed_mask_reg <= pcq_pkg::MASK_RESET;
            search_mode_reg  <= pcq_pkg::MODE_NEAREST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                pcq_pkg::REG_ALLOWED_MASK: allowed_mask_reg <= wr_data;
                pcq_pkg::REG_SEARCH_MODE:  search_mode_reg  <= wr_data[1:0];
                default: ;
            endcase
        end
    end

    // Ready chain: a stage takes an item when empty or when it drains
    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1: round half up to whole semitones, clamp to the border
    logic signed [16:0] round_sum;
    logic signed [8:0]  semi_raw;
    logic signed [8:0]  semi_clamp;

    always_comb
    begin
        round_sum = {pitch_in[15], pitch_in} + 17'sd128;
        semi_raw  = $signed(round_sum[16:8]);
        if (semi_raw > pcq_pkg::BORDER_POS)
            semi_clamp = pcq_pkg::BORDER_POS;
        else if (semi_raw < pcq_pkg::BORDER_NEG)
            semi_clamp = pcq_pkg::BORDER_NEG;
        else
            semi_clamp = semi_raw;
        s1_semi_next = semi_clamp[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_semi_reg <= s1_semi_next;
    end

    // Stage 2: pitch class = semitone mod 12 by reciprocal multiply
    logic [8:0]  pc_biased;
    logic [16:0] pc_prod;
    logic [5:0]  pc_quot;
    logic [8:0]  pc_rem;

    always_comb
    begin
        pc_biased  = 9'({s1_semi_reg[7], s1_semi_reg}) + pcq_pkg::PC_BIAS;
        pc_prod    = 17'(pc_biased) * 17'(pcq_pkg::RECIP_12);
        pc_quot    = pc_prod[16:11];
        pc_rem     = pc_biased - ({pc_quot, 3'b000} + {1'b0, pc_quot, 2'b00});
        s2_pc_next = pc_rem[3:0];
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_semi_reg <= s1_semi_reg;
            s2_pc_reg   <= s2_pc_next;
        end
    end

    // Stage 3: rotate the mask to this class, pick nearest allowed offsets
    logic [11:0] rot_mask;
    logic [4:0]  rot_idx;

    always_comb
    begin
        rot_idx = '0;
        for (int k = 0; k < 12; k++)
        begin
            rot_idx = 5'(s2_pc_reg) + 5'(k);
            if (rot_idx >= 5'd12)
                rot_idx = rot_idx - 5'd12;
            rot_mask[k] = allowed_mask_reg[rot_idx[3:0]];
        end

        s3_hit_next = rot_mask[0] || (allowed_mask_reg == '0);

        // scan from far to near so the nearest offset wins
        s3_up_dist_next = '0;
        s3_dn_dist_next = '0;
        for (int k = 11; k >= 1; k--)
        begin
            if (rot_mask[k])
                s3_up_dist_next = 4'(k);
            if (rot_mask[12 - k])
                s3_dn_dist_next = 4'(k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_semi_reg    <= s2_semi_reg;
            s3_hit_reg     <= s3_hit_next;
            s3_up_dist_reg <= s3_up_dist_next;
            s3_dn_dist_reg <= s3_dn_dist_next;
            s3_mode_reg    <= search_mode_reg;
        end
    end

    // Stage 4: apply border to the candidates and select by mode
    logic signed [8:0] up_semi, dn_semi, base_semi;
    logic              up_in, dn_in;
    logic signed [8:0] pick;

    always_comb
    begin
        base_semi = {s3_semi_reg[7], s3_semi_reg};
        up_semi   = base_semi + $signed({5'b00000, s3_up_dist_reg});
        dn_semi   = base_semi - $signed({5'b00000, s3_dn_dist_reg});
        up_in     = (up_semi <= pcq_pkg::BORDER_POS);
        dn_in     = (dn_semi >= pcq_pkg::BORDER_NEG);

        if (s3_hit_reg)
            pick = base_semi;
        else
        begin
            case (s3_mode_reg)
                pcq_pkg::MODE_UP:
                    pick = up_in ? up_semi : pcq_pkg::BORDER_POS;
                pcq_pkg::MODE_DOWN:
                    pick = dn_in ? dn_semi : pcq_pkg::BORDER_NEG;
                default:
                begin
                    // nearest, upward wins a tie
                    if (up_in && (!dn_in || s3_up_dist_reg <= s3_dn_dist_reg))
                        pick = up_semi;
                    else if (dn_in)
                        pick = dn_semi;
                    else
                        pick = base_semi;
                end
            endcase
        end
        s4_result_next = pick[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_valid_reg)
            s4_result_reg <= s4_result_next;
    end

    assign out_valid          = s4_valid_reg;
    assign quantized_semitone = s4_result_reg;

    // Results never leave the border window
    a_result_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed({quantized_semitone[7], quantized_semitone})
                           <= pcq_pkg::BORDER_POS &&
                       $signed({quantized_semitone[7], quantized_semitone})
                           >= pcq_pkg::BORDER_NEG))
        else $error("quantized semitone outside border");

    // An already allowed class passes through unchanged
    a_hit_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s4_ready && s3_hit_reg) |=>
            (s4_result_reg == $past(s3_semi_reg)))
        else $error("allowed semitone was altered");

    // Found upward and downward offsets always lie within one octave
    a_offsets_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_hit_reg) |->
            (s3_up_dist_reg != 4'd0 && s3_dn_dist_reg != 4'd0 &&
             s3_up_dist_reg <= 4'd11 && s3_dn_dist_reg <= 4'd11))
        else $error("search offset out of range with nonempty mask");

endmodule

FILE: bench/pitch_class_quantizer_tb.sv
// Testbench for pitch_class_quantizer: directed and random pitches under random config,
// checked against an in-bench quantizer model. Depends on pcq_pkg and the block only.
`timescale 1ns / 100ps

module pitch_class_quantizer_tb;

    // Tracks the register copies and the semitones still owed by the block
    class quantize_tracker;
        logic [11:0]       mask_copy;
        logic [1:0]        mode_copy;
        logic signed [7:0] expected_semis[$];
        int unsigned       errors;

        function new();
            mask_copy = pcq_pkg::MASK_RESET;
            mode_copy = pcq_pkg::MODE_NEAREST;
            errors    = 0;
        endfunction

        function void set_register(logic index, logic [11:0] data);
            if (index == pcq_pkg::REG_ALLOWED_MASK)
                mask_copy = data;
            else
                mode_copy = data[1:0];
        endfunction

        function bit class_allowed(int semi);
            return mask_copy[(semi + 1200) % 12];
        endfunction

        // Round half up, clamp, then search the mask per mode
        function logic signed [7:0] quantize_pitch(logic signed [15:0] pitch);
            int s0;
            int s;
            int d;
            bit up_in;
            bit dn_in;
            s0 = (int'(pitch) + 128) >>> 8;
            if (s0 > pcq_pkg::BORDER_SEMIS)
                s0 = pcq_pkg::BORDER_SEMIS;
            if (s0 < -pcq_pkg::BORDER_SEMIS)
                s0 = -pcq_pkg::BORDER_SEMIS;
            if (mask_copy == 12'h000 || class_allowed(s0))
                return 8'(s0);
            if (mode_copy == pcq_pkg::MODE_UP)
            begin
                for (s = s0 + 1; s <= pcq_pkg::BORDER_SEMIS; s++)
                    if (class_allowed(s))
                        return 8'(s);
                return 8'(pcq_pkg::BORDER_SEMIS);
            end
            if (mode_copy == pcq_pkg::MODE_DOWN)
            begin
                for (s = s0 - 1; s >= -pcq_pkg::BORDER_SEMIS; s--)
                    if (class_allowed(s))
                        return 8'(s);
                return 8'(-pcq_pkg::BORDER_SEMIS);
            end
            // nearest; upward candidate wins a tie
            for (d = 1; d <= 2 * pcq_pkg::BORDER_SEMIS + 1; d++)
            begin
                up_in = (s0 + d) <= pcq_pkg::BORDER_SEMIS;
                dn_in = (s0 - d) >= -pcq_pkg::BORDER_SEMIS;
                if (!up_in && !dn_in)
                    break;
                if (up_in && class_allowed(s0 + d))
                    return 8'(s0 + d);
                if (dn_in && class_allowed(s0 - d))
                    return 8'(s0 - d);
            end
            return 8'(s0);
        endfunction

        function void note_pitch(logic signed [15:0] pitch);
            expected_semis.insert(expected_semis.size(), quantize_pitch(pitch));
        endfunction

        function void check_semitone(logic signed [7:0] actual);
            logic signed [7:0] want;
            if (expected_semis.size() == 0)
            begin
                errors++;
                $display("%0t: semitone %0d arrived with none expected", $time, actual);
                return;
            end
            want = expected_semis.pop_front();
            if (actual !== want)
            begin
                errors++;
                $display("%0t: semitone expected %0d, got %0d", $time, want, actual);
            end
        endfunction

        function int pending();
            return expected_semis.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic signed [15:0] pitch_in;
    logic              out_valid;
    logic              out_ready;
    logic signed [7:0] quantized_semitone;
    logic              wr_en;
    logic              wr_index;
    logic [11:0]       wr_data;

    quantize_tracker tracker;
    bit              calm;

    pitch_class_quantizer uut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .pitch_in           (pitch_in),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .quantized_semitone (quantized_semitone),
        .wr_en              (wr_en),
        .wr_index           (wr_index),
        .wr_data            (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Register write, one cycle, only while nothing is in flight
    task automatic write_reg(input logic index, input logic [11:0] data);
        wr_en    = 1'b1;
        wr_index = index;
        wr_data  = data;
        tracker.set_register(index, data);
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    // Offer one pitch item after a random gap; returns at the following falling edge
    task automatic send_pitch(input logic signed [15:0] pitch);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        pitch_in = pitch;
        do @(posedge clk); while (!in_ready);
        tracker.note_pitch(pitch);
        @(negedge clk);
    endtask

    // Hold off until every owed semitone is out, then let the pipeline settle
    task automatic wait_drained();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Result side: random stalls, check on each accepted item
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            tracker.check_semitone(quantized_semitone);
            @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin
        int phase;
        int n;
        int val;
        logic [11:0] mask_val;
        tracker  = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        pitch_in = '0;
        wr_en    = 1'b0;
        wr_index = pcq_pkg::REG_ALLOWED_MASK;
        wr_data  = '0;
        calm     = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset config: all classes, nearest. Rounding, ties and clamping.
        send_pitch(16'sh8000);
        send_pitch(16'sh7FFF);
        send_pitch(16'sd0);
        send_pitch(16'sd127);
        send_pitch(16'sd128);
        send_pitch(-16'sd128);
        send_pitch(-16'sd129);
        send_pitch(16'sd30720);
        send_pitch(16'sd30848);
        send_pitch(-16'sd30848);
        send_pitch(-16'sd30849);
        send_pitch(16'sh5555);
        send_pitch(16'shAAAA);
        wait_drained();

        // Empty mask returns the rounded semitone
        write_reg(pcq_pkg::REG_ALLOWED_MASK, 12'h000);
        write_reg(pcq_pkg::REG_SEARCH_MODE, 12'(pcq_pkg::MODE_UP));
        send_pitch(16'sd300);
        send_pitch(16'sh8000);
        wait_drained();

        // Upward search: a found candidate, and run off the top border
        write_reg(pcq_pkg::REG_ALLOWED_MASK, 12'h002);
        send_pitch(16'sd0);
        send_pitch(16'sd30464);
        wait_drained();

        // Downward search: a found candidate, and run off the bottom border
        write_reg(pcq_pkg::REG_ALLOWED_MASK, 12'h800);
        write_reg(pcq_pkg::REG_SEARCH_MODE, 12'(pcq_pkg::MODE_DOWN));
        send_pitch(16'sd0);
        send_pitch(-16'sd30464);
        wait_drained();

        // Nearest with an equal-distance tie, then mode code three
        write_reg(pcq_pkg::REG_ALLOWED_MASK, 12'h044);
        write_reg(pcq_pkg::REG_SEARCH_MODE, 12'(pcq_pkg::MODE_NEAREST));
        send_pitch(16'sd1024);
        send_pitch(-16'sd1024);
        wait_drained();
        write_reg(pcq_pkg::REG_SEARCH_MODE, 12'(pcq_pkg::MODE_RESERVED));
        send_pitch(16'sd1024);
        send_pitch(16'sd896);
        wait_drained();

        // Random phases, each with fresh register values
        for (phase = 0; phase < 12; phase++)
        begin
            case ($urandom_range(0, 4))
                0: mask_val = 12'h000;
                1: mask_val = 12'hFFF;
                2: mask_val = 12'(1 << $urandom_range(0, 11));
                default: mask_val = 12'($urandom);
            endcase
            write_reg(pcq_pkg::REG_ALLOWED_MASK, mask_val);
            write_reg(pcq_pkg::REG_SEARCH_MODE,
                      {($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd0,
                       2'($urandom_range(0, 3))});
            calm = (phase % 4 == 1);
            for (n = 0; n < 111; n++)
            begin
                case ($urandom_range(0, 9))
                    0: val = int'($urandom_range(0, 65535)) - 32768;
                    1: val = (($urandom_range(0, 1) == 1) ? 1 : -1)
                             * pcq_pkg::BORDER_SEMIS * 256
                             + int'($urandom_range(0, 1024)) - 512;
                    2: val = (int'($urandom_range(0, 241)) - 121) * 256 + 128;
                    3: val = (int'($urandom_range(0, 241)) - 121) * 256 + 127;
                    default: val = int'($urandom_range(0, 61952)) - 30976;
                endcase
                send_pitch(16'(val));
                // occasional short idle-free burst inside a phase
                if (n % 37 == 0)
                    calm = (phase % 4 == 1) || ($urandom_range(0, 3) == 0);
            end
            wait_drained();
        end

        calm = 1'b0;
        wait_drained();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("pitch_class_quantizer: match");
        else
            $display("pitch_class_quantizer: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("pitch_class_quantizer: mismatch");
        $finish;
    end

endmodule
